/* design/acsm_pkg.sv */
// shared types, constants and curve tables for the clip / saturate / meter block
// used by every module of the block; depends on nothing
package acsm_pkg;

    localparam int LOG_DEPTH = 256;
    localparam int IDX_W     = $clog2(LOG_DEPTH + 1);

    localparam logic [22:0] ONE_Q22     = 23'd4194304;
    localparam logic [27:0] ONE_Q20     = 28'd1048576;
    localparam logic [15:0] EXP_LINEAR  = 16'd4096;
    localparam logic [15:0] RESET_GAIN  = 16'd4096;
    localparam logic [8:0]  TINY_SHIFT  = 9'd23;
    localparam logic [47:0] SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] TALLY_MAX   = 32'hFFFF_FFFF;

    localparam logic [1:0] CFG_VOLUME_GAIN    = 2'd0;
    localparam logic [1:0] CFG_CURVE_EXPONENT = 2'd1;

    typedef struct packed {
        logic signed [23:0] sample_in;
        logic               frame_last;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic               was_clipped;
        logic               frame_done;
        logic [27:0]        frame_overshoot;
        logic [47:0]        overshoot_total;
        logic [31:0]        frames_counted;
    } t_out_item;

    // everything but the curve input, carried alongside the curve pipeline
    typedef struct packed {
        logic        neg_out;
        logic        was_clipped;
        logic        frame_done;
        logic [27:0] frame_overshoot;
        logic [47:0] overshoot_total;
        logic [31:0] frames_counted;
    } t_meta;

    typedef struct packed {
        logic [22:0] mag_q22;
        t_meta       meta;
    } t_mid;

    typedef logic [31:0] t_tab [LOG_DEPTH + 1];

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v    = v_in;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // y in Q.30 within [1,2), result is the fractional log2 in Q.24
    function automatic longint unsigned log2_frac(input longint unsigned y_in);
        longint unsigned y;
        longint unsigned r;
        y = y_in;
        r = 0;
        for (int b = 0; b < 24; b++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                r = r | 64'd1;
            end
        end
        return r;
    endfunction

    function automatic t_tab build_lg();
        t_tab            tab;
        longint unsigned ii;
        for (int i = 0; i < LOG_DEPTH; i++) begin
            ii     = longint'(i);
            tab[i] = 32'(log2_frac((64'd1 << 30) + ((ii << 30) / LOG_DEPTH)));
        end
        tab[LOG_DEPTH] = 32'd1 << 24;
        return tab;
    endfunction

    function automatic t_tab build_ex();
        t_tab            tab;
        longint unsigned roots [25];
        longint unsigned ii;
        longint unsigned f;
        longint unsigned v;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 24; k++) roots[k] = isqrt64(roots[k - 1] << 30);
        for (int i = 0; i < LOG_DEPTH; i++) begin
            ii = longint'(i);
            f  = (ii << 24) / LOG_DEPTH;
            v  = 64'd1 << 30;
            for (int k = 1; k <= 24; k++) begin
                if (((f >> (24 - k)) & 64'd1) != 0) begin
                    v = (v * roots[k] + (64'd1 << 29)) >> 30;
                end
            end
            tab[i] = 32'(v);
        end
        tab[LOG_DEPTH] = 32'd1 << 31;
        return tab;
    endfunction

    localparam t_tab LG_TAB = build_lg();
    localparam t_tab EX_TAB = build_ex();

endpackage

/* design/audio_clip_saturate_meter.sv */
// Volume, hard clip to +-1, sign-preserving power curve |x|^e and a per-frame
// overshoot meter for an interleaved audio sample stream. One sample is taken per
// cycle sustained while i_ready does not stall the output; a sample passes the
// meter front, the four-entry queue and the curve pipeline (log lookup, log
// interpolate, exponent multiply, exp lookup, exp interpolate, round into the output
// register). Each result's stats include it; the total and tally update on frame_last.
// Registers: index 0 volume_gain, index 1 curve_exponent, both Q4.12, reset 4096.
// depends on acsm_pkg, acsm_front, acsm_queue, acsm_back
module audio_clip_saturate_meter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  acsm_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output acsm_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);

    logic [15:0]    r_volume_gain;
    logic [15:0]    r_curve_exponent;
    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;
    acsm_pkg::t_mid push_data;
    acsm_pkg::t_mid q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume_gain    <= acsm_pkg::RESET_GAIN;
            r_curve_exponent <= acsm_pkg::EXP_LINEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                acsm_pkg::CFG_VOLUME_GAIN:    r_volume_gain    <= i_cfg_data;
                acsm_pkg::CFG_CURVE_EXPONENT: r_curve_exponent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acsm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .i_volume_gain (r_volume_gain),
        .o_push        (push),
        .o_push_data   (push_data),
        .i_full        (full)
    );

    acsm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    acsm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .o_pop            (pop),
        .i_data           (q_data),
        .i_curve_exponent (r_curve_exponent),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_data           (o_data)
    );

endmodule

/* design/acsm_front.sv */
// front part: volume scaling, clip detection and the frame overshoot meter
// depends on acsm_pkg
module acsm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  acsm_pkg::t_in_item i_data,
    input  logic [15:0]       i_volume_gain,
    output logic              o_push,
    output acsm_pkg::t_mid    o_push_data,
    input  logic              i_full
);

    logic        r_v;
    logic [27:0] r_mag;
    logic        r_neg;
    logic        r_last;
    logic [27:0] r_peak;
    logic [47:0] r_sum;
    logic [31:0] r_tally;

    logic [23:0] absin;
    logic [39:0] prod;
    logic        clip;
    logic [27:0] peak_new;
    logic [48:0] sum_wide;
    logic [47:0] n_sum;
    logic [31:0] n_tally;
    logic [27:0] clipped;

    assign o_push  = r_v && !i_full;
    assign o_ready = !r_v || o_push;

    assign absin = i_data.sample_in[23] ? (~i_data.sample_in + 24'd1) : i_data.sample_in;
    assign prod  = 40'(absin) * 40'(i_volume_gain);

    always_comb begin
        clip     = r_mag > acsm_pkg::ONE_Q20;
        clipped  = clip ? acsm_pkg::ONE_Q20 : r_mag;
        peak_new = (clip && r_mag > r_peak) ? r_mag : r_peak;
        sum_wide = {1'b0, r_sum} + 49'(peak_new);
        n_sum    = r_sum;
        n_tally  = r_tally;
        if (r_last) begin
            n_sum   = sum_wide[48] ? acsm_pkg::SUM_MAX : sum_wide[47:0];
            n_tally = (r_tally == acsm_pkg::TALLY_MAX) ? r_tally : r_tally + 32'd1;
        end
        o_push_data.mag_q22              = {clipped[20:0], 2'b00};
        o_push_data.meta.neg_out         = r_neg && (r_mag != 28'd0);
        o_push_data.meta.was_clipped     = clip;
        o_push_data.meta.frame_done      = r_last;
        o_push_data.meta.frame_overshoot = peak_new;
        o_push_data.meta.overshoot_total = n_sum;
        o_push_data.meta.frames_counted  = n_tally;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_peak  <= '0;
            r_sum   <= '0;
            r_tally <= '0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (o_push) begin
                r_peak  <= r_last ? 28'd0 : peak_new;
                r_sum   <= n_sum;
                r_tally <= n_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag  <= prod[39:12];
            r_neg  <= i_data.sample_in[23];
            r_last <= i_data.frame_last;
        end
    end

endmodule

/* design/acsm_queue.sv */
// short queue between the meter front and the curve back end
// depends on acsm_pkg
module acsm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  acsm_pkg::t_mid i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output acsm_pkg::t_mid o_data
);

    acsm_pkg::t_mid r_mem [4];
    logic [1:0]     r_wr;
    logic [1:0]     r_rd;
    logic [2:0]     r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 2'd1;
            if (i_pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

/* design/acsm_back.sv */
// back end: power curve |x|^e through log2 / exp2 tables, sign and output register
// depends on acsm_pkg
module acsm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_pop,
    input  acsm_pkg::t_mid      i_data,
    input  logic [15:0]         i_curve_exponent,
    output logic                o_valid,
    input  logic                i_ready,
    output acsm_pkg::t_out_item o_data
);

    localparam int IW = acsm_pkg::IDX_W;

    logic                 adv;
    logic [5:0]           r_v;
    acsm_pkg::t_meta      r_meta [5];
    logic [4:0]           r_byp;
    logic [22:0]          r_byp_val [5];
    logic [4:0]           r_zero;

    // stage 1 to 2
    logic [31:0] r1_a, r1_d;
    logic [21:0] r1_rem;
    logic [4:0]  r1_lz;
    // stage 2 to 3
    logic [28:0] r2_neg;
    // stage 3 to 4
    logic [32:0] r3_t;
    // stage 4 to 5
    logic [31:0] r4_a, r4_d;
    logic [23:0] r4_rem;
    logic [4:0]  r4_n;
    // stage 5 to 6
    logic [31:0] r5_v;
    logic [4:0]  r5_n;

    logic [22:0]      x;
    logic             byp;
    logic [22:0]      byp_val;
    logic [4:0]       p;
    logic [4:0]       lz;
    logic [22:0]      xs;
    logic [21:0]      frac;
    logic [22+IW-1:0] fpos;
    logic [IW-1:0]    idx1;
    logic [46:0]      lprod;
    logic [24:0]      lf;
    logic [44:0]      tprod;
    logic [24:0]      g;
    logic [25+IW-1:0] gpos;
    logic [IW-1:0]    idx4, idx4_hi;
    logic             tiny;
    logic [55:0]      eprod;
    logic [32:0]      rnd;
    logic [32:0]      ysh;
    logic [22:0]      y;
    logic [23:0]      ymag;

    assign adv   = !r_v[5] || i_ready;
    assign o_pop = adv && i_valid;
    assign o_valid = r_v[5];

    // stage 1: special cases, leading one, log table lookup
    always_comb begin
        x       = i_data.mag_q22;
        byp     = 1'b1;
        byp_val = x;
        if (i_curve_exponent == 16'd0) begin
            byp_val = acsm_pkg::ONE_Q22;
        end else if (x == 23'd0) begin
            byp_val = 23'd0;
        end else if (i_curve_exponent == acsm_pkg::EXP_LINEAR || x >= acsm_pkg::ONE_Q22) begin
            byp_val = x;
        end else begin
            byp = 1'b0;
        end
        p = 5'd0;
        for (int k = 0; k < 22; k++) begin
            if (x[k]) p = 5'(k);
        end
        lz   = 5'd22 - p;
        xs   = x << lz;
        frac = xs[21:0];
        fpos = (22+IW)'(frac) * (22+IW)'(acsm_pkg::LOG_DEPTH);
        idx1 = fpos[22 +: IW];
    end

    // stage 2: interpolate log, form negative log
    always_comb begin
        lprod = 47'(r1_d[24:0]) * 47'(r1_rem);
        lf    = 25'(r1_a) + 25'(lprod[46:22]);
    end

    // stage 3: scale by the exponent
    assign tprod = 45'(r2_neg) * 45'(i_curve_exponent);

    // stage 4: exp table lookup
    always_comb begin
        tiny    = r3_t[32:24] >= acsm_pkg::TINY_SHIFT;
        g       = 25'd16777216 - 25'(r3_t[23:0]);
        gpos    = (25+IW)'(g) * (25+IW)'(acsm_pkg::LOG_DEPTH);
        idx4    = gpos[24 +: IW];
        idx4_hi = (idx4 == IW'(acsm_pkg::LOG_DEPTH)) ? idx4 : idx4 + IW'(1);
    end

    // stage 5: interpolate exp
    assign eprod = 56'(r4_d[24:0]) * 56'(r4_rem);

    // stage 6: round at the final shift, limit, apply sign
    always_comb begin
        rnd  = 33'(r5_v) + (33'd1 << (5'd8 + r5_n));
        ysh  = rnd >> (5'd9 + r5_n);
        y    = (ysh > 33'(acsm_pkg::ONE_Q22)) ? acsm_pkg::ONE_Q22 : ysh[22:0];
        if (r_byp[4]) begin
            y = r_byp_val[4];
        end else if (r_zero[4]) begin
            y = 23'd0;
        end
        ymag = 24'(y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_meta[0]    <= i_data.meta;
            r_byp[0]     <= byp;
            r_byp_val[0] <= byp_val;
            r_zero[0]    <= 1'b0;
            r1_a         <= acsm_pkg::LG_TAB[idx1];
            r1_d         <= acsm_pkg::LG_TAB[idx1 + IW'(1)] - acsm_pkg::LG_TAB[idx1];
            r1_rem       <= fpos[21:0];
            r1_lz        <= lz;

            r_meta[1]    <= r_meta[0];
            r_byp[1]     <= r_byp[0];
            r_byp_val[1] <= r_byp_val[0];
            r_zero[1]    <= r_zero[0];
            r2_neg       <= {r1_lz, 24'd0} - 29'(lf);

            r_meta[2]    <= r_meta[1];
            r_byp[2]     <= r_byp[1];
            r_byp_val[2] <= r_byp_val[1];
            r_zero[2]    <= r_zero[1];
            r3_t         <= tprod[44:12];

            r_meta[3]    <= r_meta[2];
            r_byp[3]     <= r_byp[2];
            r_byp_val[3] <= r_byp_val[2];
            r_zero[3]    <= tiny;
            r4_a         <= acsm_pkg::EX_TAB[idx4];
            r4_d         <= acsm_pkg::EX_TAB[idx4_hi] - acsm_pkg::EX_TAB[idx4];
            r4_rem       <= gpos[23:0];
            r4_n         <= r3_t[28:24];

            r_meta[4]    <= r_meta[3];
            r_byp[4]     <= r_byp[3];
            r_byp_val[4] <= r_byp_val[3];
            r_zero[4]    <= r_zero[3];
            r5_v         <= r4_a + 32'(eprod[55:24]);
            r5_n         <= r4_n;

            o_data.sample_out      <= r_meta[4].neg_out ? (~ymag + 24'd1) : ymag;
            o_data.was_clipped     <= r_meta[4].was_clipped;
            o_data.frame_done      <= r_meta[4].frame_done;
            o_data.frame_overshoot <= r_meta[4].frame_overshoot;
            o_data.overshoot_total <= r_meta[4].overshoot_total;
            o_data.frames_counted  <= r_meta[4].frames_counted;
        end
    end

endmodule
